>>> src/esc_pkg.sv
// Shared types, codes, constants and microcode ROM of the sensor compensation core.
`timescale 1ns / 1ps
package esc_pkg;

   // ALU operations
   localparam logic [3:0] OP_ADD   = 4'd0;
   localparam logic [3:0] OP_SUB   = 4'd1;
   localparam logic [3:0] OP_MUL   = 4'd2;
   localparam logic [3:0] OP_DIV   = 4'd3;
   localparam logic [3:0] OP_ASR   = 4'd4;
   localparam logic [3:0] OP_SHL   = 4'd5;
   localparam logic [3:0] OP_LSR   = 4'd6;
   localparam logic [3:0] OP_ZSEL  = 4'd7;
   localparam logic [3:0] OP_DINP  = 4'd8;
   localparam logic [3:0] OP_DOUTP = 4'd9;
   localparam logic [3:0] OP_HFIN  = 4'd10;

   // result width modes
   localparam logic [1:0] MODE_W64 = 2'd0;
   localparam logic [1:0] MODE_S32 = 2'd1;
   localparam logic [1:0] MODE_U32 = 2'd2;

   // operand sources: scratch registers, then trims, state, inputs, constants
   localparam logic [5:0] SRC_R0 = 6'd0;
   localparam logic [5:0] SRC_R1 = 6'd1;
   localparam logic [5:0] SRC_R2 = 6'd2;
   localparam logic [5:0] SRC_R3 = 6'd3;
   localparam logic [5:0] SRC_R4 = 6'd4;
   localparam logic [5:0] SRC_R5 = 6'd5;
   localparam logic [5:0] SRC_R6 = 6'd6;
   localparam logic [5:0] SRC_R7 = 6'd7;
   localparam logic [5:0] SRC_T1 = 6'd16;
   localparam logic [5:0] SRC_T2 = 6'd17;
   localparam logic [5:0] SRC_T3 = 6'd18;
   localparam logic [5:0] SRC_P1 = 6'd19;
   localparam logic [5:0] SRC_P2 = 6'd20;
   localparam logic [5:0] SRC_P3 = 6'd21;
   localparam logic [5:0] SRC_P4 = 6'd22;
   localparam logic [5:0] SRC_P5 = 6'd23;
   localparam logic [5:0] SRC_P6 = 6'd24;
   localparam logic [5:0] SRC_P7 = 6'd25;
   localparam logic [5:0] SRC_P8 = 6'd26;
   localparam logic [5:0] SRC_P9 = 6'd27;
   localparam logic [5:0] SRC_H1 = 6'd28;
   localparam logic [5:0] SRC_H2 = 6'd29;
   localparam logic [5:0] SRC_H3 = 6'd30;
   localparam logic [5:0] SRC_H4 = 6'd31;
   localparam logic [5:0] SRC_H5 = 6'd32;
   localparam logic [5:0] SRC_H6 = 6'd33;
   localparam logic [5:0] SRC_FINE = 6'd34;
   localparam logic [5:0] SRC_RT = 6'd35;
   localparam logic [5:0] SRC_RP = 6'd36;
   localparam logic [5:0] SRC_RH = 6'd37;
   localparam logic [5:0] SRC_K128000 = 6'd39;
   localparam logic [5:0] SRC_K3125 = 6'd40;
   localparam logic [5:0] SRC_K1048576 = 6'd41;
   localparam logic [5:0] SRC_K64000 = 6'd42;
   localparam logic [5:0] SRC_K76800 = 6'd43;
   localparam logic [5:0] SRC_K16384 = 6'd44;
   localparam logic [5:0] SRC_K2097152 = 6'd45;
   localparam logic [5:0] SRC_K128 = 6'd46;
   localparam logic [5:0] SRC_K5 = 6'd47;
   localparam logic [5:0] SRC_K2P47 = 6'd48;
   localparam logic [5:0] SRC_K32768 = 6'd49;
   localparam logic [5:0] SRC_K8192 = 6'd50;

   // destinations
   localparam logic [4:0] DST_R0 = 5'd0;
   localparam logic [4:0] DST_R1 = 5'd1;
   localparam logic [4:0] DST_R2 = 5'd2;
   localparam logic [4:0] DST_R3 = 5'd3;
   localparam logic [4:0] DST_R4 = 5'd4;
   localparam logic [4:0] DST_R5 = 5'd5;
   localparam logic [4:0] DST_R6 = 5'd6;
   localparam logic [4:0] DST_R7 = 5'd7;
   localparam logic [4:0] DST_FINE = 5'd16;
   localparam logic [4:0] DST_OUT_T = 5'd17;
   localparam logic [4:0] DST_OUT_P = 5'd18;
   localparam logic [4:0] DST_OUT_H = 5'd19;

   // register indexes of the write port
   localparam logic [2:0] CSR_TEMP_TRIM   = 3'd0;
   localparam logic [2:0] CSR_PRESS_LOW   = 3'd1;
   localparam logic [2:0] CSR_PRESS_HIGH  = 3'd2;
   localparam logic [2:0] CSR_PRESS_NINTH = 3'd3;
   localparam logic [2:0] CSR_HUM_TRIM    = 3'd4;
   localparam logic [2:0] CSR_PRESS_FMT   = 3'd5;

   localparam logic [19:0] SKIP_TP = 20'h80000;
   localparam logic [15:0] SKIP_H  = 16'h8000;
   localparam logic [63:0] K_HUM_MAX = 64'd419430400;

   // microcode segment entry points
   localparam logic [6:0] PC_TEMP = 7'd0;
   localparam logic [6:0] PC_P64  = 7'd15;
   localparam logic [6:0] PC_P32  = 7'd48;
   localparam logic [6:0] PC_HUM  = 7'd90;

   typedef struct packed {
      logic [47:0] temp;
      logic [63:0] plow;
      logic [63:0] phigh;
      logic [15:0] p9;
      logic [63:0] hum;
   } trim_type;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] mode;
      logic [4:0] dst;
      logic [5:0] src_a;
      logic [5:0] src_b;
      logic [5:0] sh;
      logic       last;
   } uop_type;

   typedef struct packed {
      logic       start;
      logic [3:0] op;
      logic [1:0] mode;
      logic [5:0] sh;
   } alu_ctl_type;

   function automatic uop_type esc_mk(input logic [3:0] op, input logic [1:0] mode,
                                      input logic [4:0] dst, input logic [5:0] a,
                                      input logic [5:0] b, input logic [5:0] sh,
                                      input logic last);
      uop_type u;
      u.op = op;
      u.mode = mode;
      u.dst = dst;
      u.src_a = a;
      u.src_b = b;
      u.sh = sh;
      u.last = last;
      return u;
   endfunction

   function automatic uop_type esc_ucode(input logic [6:0] pc);
      uop_type u;
      case (pc)
         // temperature
         PC_TEMP + 7'd0:  u = esc_mk(OP_LSR, MODE_S32, DST_R0, SRC_RT, SRC_R0, 6'd3, 1'b0);
         PC_TEMP + 7'd1:  u = esc_mk(OP_SHL, MODE_S32, DST_R1, SRC_T1, SRC_R0, 6'd1, 1'b0);
         PC_TEMP + 7'd2:  u = esc_mk(OP_SUB, MODE_S32, DST_R0, SRC_R0, SRC_R1, 6'd0, 1'b0);
         PC_TEMP + 7'd3:  u = esc_mk(OP_MUL, MODE_S32, DST_R0, SRC_R0, SRC_T2, 6'd0, 1'b0);
         PC_TEMP + 7'd4:  u = esc_mk(OP_ASR, MODE_S32, DST_R0, SRC_R0, SRC_R0, 6'd11, 1'b0);
         PC_TEMP + 7'd5:  u = esc_mk(OP_LSR, MODE_S32, DST_R1, SRC_RT, SRC_R0, 6'd4, 1'b0);
         PC_TEMP + 7'd6:  u = esc_mk(OP_SUB, MODE_S32, DST_R1, SRC_R1, SRC_T1, 6'd0, 1'b0);
         PC_TEMP + 7'd7:  u = esc_mk(OP_MUL, MODE_S32, DST_R1, SRC_R1, SRC_R1, 6'd0, 1'b0);
         PC_TEMP + 7'd8:  u = esc_mk(OP_ASR, MODE_S32, DST_R1, SRC_R1, SRC_R0, 6'd12, 1'b0);
         PC_TEMP + 7'd9:  u = esc_mk(OP_MUL, MODE_S32, DST_R1, SRC_R1, SRC_T3, 6'd0, 1'b0);
         PC_TEMP + 7'd10: u = esc_mk(OP_ASR, MODE_S32, DST_R1, SRC_R1, SRC_R0, 6'd14, 1'b0);
         PC_TEMP + 7'd11: u = esc_mk(OP_ADD, MODE_S32, DST_FINE, SRC_R0, SRC_R1, 6'd0, 1'b0);
         PC_TEMP + 7'd12: u = esc_mk(OP_MUL, MODE_S32, DST_R0, SRC_FINE, SRC_K5, 6'd0, 1'b0);
         PC_TEMP + 7'd13: u = esc_mk(OP_ADD, MODE_S32, DST_R0, SRC_R0, SRC_K128, 6'd0, 1'b0);
         PC_TEMP + 7'd14: u = esc_mk(OP_ASR, MODE_S32, DST_OUT_T, SRC_R0, SRC_R0, 6'd8, 1'b1);
         // pressure, 64-bit path
         PC_P64 + 7'd0:  u = esc_mk(OP_SUB, MODE_W64, DST_R0, SRC_FINE, SRC_K128000, 6'd0, 1'b0);
         PC_P64 + 7'd1:  u = esc_mk(OP_MUL, MODE_W64, DST_R1, SRC_R0, SRC_R0, 6'd0, 1'b0);
         PC_P64 + 7'd2:  u = esc_mk(OP_MUL, MODE_W64, DST_R2, SRC_R1, SRC_P6, 6'd0, 1'b0);
         PC_P64 + 7'd3:  u = esc_mk(OP_MUL, MODE_W64, DST_R3, SRC_R0, SRC_P5, 6'd0, 1'b0);
         PC_P64 + 7'd4:  u = esc_mk(OP_SHL, MODE_W64, DST_R3, SRC_R3, SRC_R0, 6'd17, 1'b0);
         PC_P64 + 7'd5:  u = esc_mk(OP_ADD, MODE_W64, DST_R2, SRC_R2, SRC_R3, 6'd0, 1'b0);
         PC_P64 + 7'd6:  u = esc_mk(OP_SHL, MODE_W64, DST_R3, SRC_P4, SRC_R0, 6'd35, 1'b0);
         PC_P64 + 7'd7:  u = esc_mk(OP_ADD, MODE_W64, DST_R2, SRC_R2, SRC_R3, 6'd0, 1'b0);
         PC_P64 + 7'd8:  u = esc_mk(OP_MUL, MODE_W64, DST_R3, SRC_R1, SRC_P3, 6'd0, 1'b0);
         PC_P64 + 7'd9:  u = esc_mk(OP_ASR, MODE_W64, DST_R3, SRC_R3, SRC_R0, 6'd8, 1'b0);
         PC_P64 + 7'd10: u = esc_mk(OP_MUL, MODE_W64, DST_R4, SRC_R0, SRC_P2, 6'd0, 1'b0);
         PC_P64 + 7'd11: u = esc_mk(OP_SHL, MODE_W64, DST_R4, SRC_R4, SRC_R0, 6'd12, 1'b0);
         PC_P64 + 7'd12: u = esc_mk(OP_ADD, MODE_W64, DST_R3, SRC_R3, SRC_R4, 6'd0, 1'b0);
         PC_P64 + 7'd13: u = esc_mk(OP_ADD, MODE_W64, DST_R3, SRC_R3, SRC_K2P47, 6'd0, 1'b0);
         PC_P64 + 7'd14: u = esc_mk(OP_MUL, MODE_W64, DST_R3, SRC_R3, SRC_P1, 6'd0, 1'b0);
         PC_P64 + 7'd15: u = esc_mk(OP_ASR, MODE_W64, DST_R3, SRC_R3, SRC_R0, 6'd33, 1'b0);
         PC_P64 + 7'd16: u = esc_mk(OP_SUB, MODE_W64, DST_R4, SRC_K1048576, SRC_RP, 6'd0, 1'b0);
         PC_P64 + 7'd17: u = esc_mk(OP_SHL, MODE_W64, DST_R4, SRC_R4, SRC_R0, 6'd31, 1'b0);
         PC_P64 + 7'd18: u = esc_mk(OP_SUB, MODE_W64, DST_R4, SRC_R4, SRC_R2, 6'd0, 1'b0);
         PC_P64 + 7'd19: u = esc_mk(OP_MUL, MODE_W64, DST_R4, SRC_R4, SRC_K3125, 6'd0, 1'b0);
         PC_P64 + 7'd20: u = esc_mk(OP_DIV, MODE_W64, DST_R4, SRC_R4, SRC_R3, 6'd0, 1'b0);
         PC_P64 + 7'd21: u = esc_mk(OP_ASR, MODE_W64, DST_R5, SRC_R4, SRC_R0, 6'd13, 1'b0);
         PC_P64 + 7'd22: u = esc_mk(OP_MUL, MODE_W64, DST_R6, SRC_P9, SRC_R5, 6'd0, 1'b0);
         PC_P64 + 7'd23: u = esc_mk(OP_MUL, MODE_W64, DST_R6, SRC_R6, SRC_R5, 6'd0, 1'b0);
         PC_P64 + 7'd24: u = esc_mk(OP_ASR, MODE_W64, DST_R6, SRC_R6, SRC_R0, 6'd25, 1'b0);
         PC_P64 + 7'd25: u = esc_mk(OP_MUL, MODE_W64, DST_R7, SRC_P8, SRC_R4, 6'd0, 1'b0);
         PC_P64 + 7'd26: u = esc_mk(OP_ASR, MODE_W64, DST_R7, SRC_R7, SRC_R0, 6'd19, 1'b0);
         PC_P64 + 7'd27: u = esc_mk(OP_ADD, MODE_W64, DST_R4, SRC_R4, SRC_R6, 6'd0, 1'b0);
         PC_P64 + 7'd28: u = esc_mk(OP_ADD, MODE_W64, DST_R4, SRC_R4, SRC_R7, 6'd0, 1'b0);
         PC_P64 + 7'd29: u = esc_mk(OP_ASR, MODE_W64, DST_R4, SRC_R4, SRC_R0, 6'd8, 1'b0);
         PC_P64 + 7'd30: u = esc_mk(OP_SHL, MODE_W64, DST_R6, SRC_P7, SRC_R0, 6'd4, 1'b0);
         PC_P64 + 7'd31: u = esc_mk(OP_ADD, MODE_W64, DST_R4, SRC_R4, SRC_R6, 6'd0, 1'b0);
         PC_P64 + 7'd32: u = esc_mk(OP_ZSEL, MODE_U32, DST_OUT_P, SRC_R4, SRC_R3, 6'd0, 1'b1);
         // pressure, 32-bit path
         PC_P32 + 7'd0:  u = esc_mk(OP_ASR, MODE_S32, DST_R0, SRC_FINE, SRC_R0, 6'd1, 1'b0);
         PC_P32 + 7'd1:  u = esc_mk(OP_SUB, MODE_S32, DST_R0, SRC_R0, SRC_K64000, 6'd0, 1'b0);
         PC_P32 + 7'd2:  u = esc_mk(OP_ASR, MODE_S32, DST_R1, SRC_R0, SRC_R0, 6'd2, 1'b0);
         PC_P32 + 7'd3:  u = esc_mk(OP_MUL, MODE_S32, DST_R1, SRC_R1, SRC_R1, 6'd0, 1'b0);
         PC_P32 + 7'd4:  u = esc_mk(OP_ASR, MODE_S32, DST_R2, SRC_R1, SRC_R0, 6'd11, 1'b0);
         PC_P32 + 7'd5:  u = esc_mk(OP_MUL, MODE_S32, DST_R2, SRC_R2, SRC_P6, 6'd0, 1'b0);
         PC_P32 + 7'd6:  u = esc_mk(OP_MUL, MODE_S32, DST_R3, SRC_R0, SRC_P5, 6'd0, 1'b0);
         PC_P32 + 7'd7:  u = esc_mk(OP_SHL, MODE_S32, DST_R3, SRC_R3, SRC_R0, 6'd1, 1'b0);
         PC_P32 + 7'd8:  u = esc_mk(OP_ADD, MODE_S32, DST_R2, SRC_R2, SRC_R3, 6'd0, 1'b0);
         PC_P32 + 7'd9:  u = esc_mk(OP_ASR, MODE_S32, DST_R2, SRC_R2, SRC_R0, 6'd2, 1'b0);
         PC_P32 + 7'd10: u = esc_mk(OP_SHL, MODE_S32, DST_R3, SRC_P4, SRC_R0, 6'd16, 1'b0);
         PC_P32 + 7'd11: u = esc_mk(OP_ADD, MODE_S32, DST_R2, SRC_R2, SRC_R3, 6'd0, 1'b0);
         PC_P32 + 7'd12: u = esc_mk(OP_ASR, MODE_S32, DST_R3, SRC_R1, SRC_R0, 6'd13, 1'b0);
         PC_P32 + 7'd13: u = esc_mk(OP_MUL, MODE_S32, DST_R3, SRC_P3, SRC_R3, 6'd0, 1'b0);
         PC_P32 + 7'd14: u = esc_mk(OP_ASR, MODE_S32, DST_R3, SRC_R3, SRC_R0, 6'd3, 1'b0);
         PC_P32 + 7'd15: u = esc_mk(OP_MUL, MODE_S32, DST_R4, SRC_P2, SRC_R0, 6'd0, 1'b0);
         PC_P32 + 7'd16: u = esc_mk(OP_ASR, MODE_S32, DST_R4, SRC_R4, SRC_R0, 6'd1, 1'b0);
         PC_P32 + 7'd17: u = esc_mk(OP_ADD, MODE_S32, DST_R3, SRC_R3, SRC_R4, 6'd0, 1'b0);
         PC_P32 + 7'd18: u = esc_mk(OP_ASR, MODE_S32, DST_R3, SRC_R3, SRC_R0, 6'd18, 1'b0);
         PC_P32 + 7'd19: u = esc_mk(OP_ADD, MODE_S32, DST_R3, SRC_K32768, SRC_R3, 6'd0, 1'b0);
         PC_P32 + 7'd20: u = esc_mk(OP_MUL, MODE_S32, DST_R3, SRC_R3, SRC_P1, 6'd0, 1'b0);
         PC_P32 + 7'd21: u = esc_mk(OP_ASR, MODE_U32, DST_R3, SRC_R3, SRC_R0, 6'd15, 1'b0);
         PC_P32 + 7'd22: u = esc_mk(OP_SUB, MODE_S32, DST_R4, SRC_K1048576, SRC_RP, 6'd0, 1'b0);
         PC_P32 + 7'd23: u = esc_mk(OP_ASR, MODE_S32, DST_R6, SRC_R2, SRC_R0, 6'd12, 1'b0);
         PC_P32 + 7'd24: u = esc_mk(OP_SUB, MODE_S32, DST_R4, SRC_R4, SRC_R6, 6'd0, 1'b0);
         PC_P32 + 7'd25: u = esc_mk(OP_MUL, MODE_U32, DST_R4, SRC_R4, SRC_K3125, 6'd0, 1'b0);
         PC_P32 + 7'd26: u = esc_mk(OP_DINP, MODE_U32, DST_R6, SRC_R4, SRC_R0, 6'd0, 1'b0);
         PC_P32 + 7'd27: u = esc_mk(OP_DIV, MODE_U32, DST_R6, SRC_R6, SRC_R3, 6'd0, 1'b0);
         PC_P32 + 7'd28: u = esc_mk(OP_DOUTP, MODE_U32, DST_R4, SRC_R4, SRC_R6, 6'd0, 1'b0);
         PC_P32 + 7'd29: u = esc_mk(OP_LSR, MODE_U32, DST_R5, SRC_R4, SRC_R0, 6'd3, 1'b0);
         PC_P32 + 7'd30: u = esc_mk(OP_MUL, MODE_U32, DST_R5, SRC_R5, SRC_R5, 6'd0, 1'b0);
         PC_P32 + 7'd31: u = esc_mk(OP_LSR, MODE_U32, DST_R5, SRC_R5, SRC_R0, 6'd13, 1'b0);
         PC_P32 + 7'd32: u = esc_mk(OP_MUL, MODE_S32, DST_R5, SRC_P9, SRC_R5, 6'd0, 1'b0);
         PC_P32 + 7'd33: u = esc_mk(OP_ASR, MODE_S32, DST_R5, SRC_R5, SRC_R0, 6'd12, 1'b0);
         PC_P32 + 7'd34: u = esc_mk(OP_LSR, MODE_U32, DST_R6, SRC_R4, SRC_R0, 6'd2, 1'b0);
         PC_P32 + 7'd35: u = esc_mk(OP_MUL, MODE_S32, DST_R6, SRC_R6, SRC_P8, 6'd0, 1'b0);
         PC_P32 + 7'd36: u = esc_mk(OP_ASR, MODE_S32, DST_R6, SRC_R6, SRC_R0, 6'd13, 1'b0);
         PC_P32 + 7'd37: u = esc_mk(OP_ADD, MODE_S32, DST_R5, SRC_R5, SRC_R6, 6'd0, 1'b0);
         PC_P32 + 7'd38: u = esc_mk(OP_ADD, MODE_S32, DST_R5, SRC_R5, SRC_P7, 6'd0, 1'b0);
         PC_P32 + 7'd39: u = esc_mk(OP_ASR, MODE_S32, DST_R5, SRC_R5, SRC_R0, 6'd4, 1'b0);
         PC_P32 + 7'd40: u = esc_mk(OP_ADD, MODE_U32, DST_R5, SRC_R4, SRC_R5, 6'd0, 1'b0);
         PC_P32 + 7'd41: u = esc_mk(OP_ZSEL, MODE_U32, DST_OUT_P, SRC_R5, SRC_R3, 6'd0, 1'b1);
         // humidity
         PC_HUM + 7'd0:  u = esc_mk(OP_SUB, MODE_S32, DST_R0, SRC_FINE, SRC_K76800, 6'd0, 1'b0);
         PC_HUM + 7'd1:  u = esc_mk(OP_SHL, MODE_S32, DST_R1, SRC_RH, SRC_R0, 6'd14, 1'b0);
         PC_HUM + 7'd2:  u = esc_mk(OP_SHL, MODE_S32, DST_R2, SRC_H4, SRC_R0, 6'd20, 1'b0);
         PC_HUM + 7'd3:  u = esc_mk(OP_SUB, MODE_S32, DST_R1, SRC_R1, SRC_R2, 6'd0, 1'b0);
         PC_HUM + 7'd4:  u = esc_mk(OP_MUL, MODE_S32, DST_R2, SRC_H5, SRC_R0, 6'd0, 1'b0);
         PC_HUM + 7'd5:  u = esc_mk(OP_SUB, MODE_S32, DST_R1, SRC_R1, SRC_R2, 6'd0, 1'b0);
         PC_HUM + 7'd6:  u = esc_mk(OP_ADD, MODE_S32, DST_R1, SRC_R1, SRC_K16384, 6'd0, 1'b0);
         PC_HUM + 7'd7:  u = esc_mk(OP_ASR, MODE_S32, DST_R1, SRC_R1, SRC_R0, 6'd15, 1'b0);
         PC_HUM + 7'd8:  u = esc_mk(OP_MUL, MODE_S32, DST_R2, SRC_R0, SRC_H6, 6'd0, 1'b0);
         PC_HUM + 7'd9:  u = esc_mk(OP_ASR, MODE_S32, DST_R2, SRC_R2, SRC_R0, 6'd10, 1'b0);
         PC_HUM + 7'd10: u = esc_mk(OP_MUL, MODE_S32, DST_R3, SRC_R0, SRC_H3, 6'd0, 1'b0);
         PC_HUM + 7'd11: u = esc_mk(OP_ASR, MODE_S32, DST_R3, SRC_R3, SRC_R0, 6'd11, 1'b0);
         PC_HUM + 7'd12: u = esc_mk(OP_ADD, MODE_S32, DST_R3, SRC_R3, SRC_K32768, 6'd0, 1'b0);
         PC_HUM + 7'd13: u = esc_mk(OP_MUL, MODE_S32, DST_R2, SRC_R2, SRC_R3, 6'd0, 1'b0);
         PC_HUM + 7'd14: u = esc_mk(OP_ASR, MODE_S32, DST_R2, SRC_R2, SRC_R0, 6'd10, 1'b0);
         PC_HUM + 7'd15: u = esc_mk(OP_ADD, MODE_S32, DST_R2, SRC_R2, SRC_K2097152, 6'd0, 1'b0);
         PC_HUM + 7'd16: u = esc_mk(OP_MUL, MODE_S32, DST_R2, SRC_R2, SRC_H2, 6'd0, 1'b0);
         PC_HUM + 7'd17: u = esc_mk(OP_ADD, MODE_S32, DST_R2, SRC_R2, SRC_K8192, 6'd0, 1'b0);
         PC_HUM + 7'd18: u = esc_mk(OP_ASR, MODE_S32, DST_R2, SRC_R2, SRC_R0, 6'd14, 1'b0);
         PC_HUM + 7'd19: u = esc_mk(OP_MUL, MODE_S32, DST_R1, SRC_R1, SRC_R2, 6'd0, 1'b0);
         PC_HUM + 7'd20: u = esc_mk(OP_ASR, MODE_S32, DST_R2, SRC_R1, SRC_R0, 6'd15, 1'b0);
         PC_HUM + 7'd21: u = esc_mk(OP_MUL, MODE_S32, DST_R2, SRC_R2, SRC_R2, 6'd0, 1'b0);
         PC_HUM + 7'd22: u = esc_mk(OP_ASR, MODE_S32, DST_R2, SRC_R2, SRC_R0, 6'd7, 1'b0);
         PC_HUM + 7'd23: u = esc_mk(OP_MUL, MODE_S32, DST_R2, SRC_R2, SRC_H1, 6'd0, 1'b0);
         PC_HUM + 7'd24: u = esc_mk(OP_ASR, MODE_S32, DST_R2, SRC_R2, SRC_R0, 6'd4, 1'b0);
         PC_HUM + 7'd25: u = esc_mk(OP_SUB, MODE_S32, DST_R1, SRC_R1, SRC_R2, 6'd0, 1'b0);
         PC_HUM + 7'd26: u = esc_mk(OP_HFIN, MODE_U32, DST_OUT_H, SRC_R1, SRC_R0, 6'd0, 1'b1);
         default:        u = esc_mk(OP_ADD, MODE_W64, DST_R0, SRC_R0, SRC_R0, 6'd0, 1'b1);
      endcase
      return u;
   endfunction

endpackage

>>> src/esc_alu.sv
// Shared arithmetic unit: registered add, shift and select, 4-step multiply, 64-step divide.
`timescale 1ns / 1ps
module esc_alu (
   input  logic                      clock,
   input  logic                      reset,
   input  esc_pkg::alu_ctl_type      ctl,
   input  logic [63:0]               a,
   input  logic [63:0]               b,
   output logic                      done,
   output logic [63:0]               result
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [3:0]  op_ff;
   logic [1:0]  mode_ff;
   logic [63:0] a_ff;
   logic [63:0] b_ff;
   logic [63:0] acc_ff;
   logic [63:0] acc_in;
   logic [63:0] rem_ff;
   logic [63:0] rem_in;
   logic [63:0] quo_ff;
   logic [63:0] quo_in;
   logic        neg_ff;
   logic [63:0] res_ff;
   logic [63:0] simple;
   logic [79:0] part;
   logic [15:0] chunk;
   logic [64:0] rem_sh;
   logic [64:0] diff;
   logic [63:0] quo_signed;

   function automatic logic [63:0] fit(input logic [1:0] mode, input logic [63:0] v);
      logic [63:0] r;
      case (mode)
         esc_pkg::MODE_S32: r = {{32{v[31]}}, v[31:0]};
         esc_pkg::MODE_U32: r = {32'd0, v[31:0]};
         default:           r = v;
      endcase
      return r;
   endfunction

   always_comb begin
      case (ctl.op)
         esc_pkg::OP_ADD:   simple = a + b;
         esc_pkg::OP_SUB:   simple = a - b;
         esc_pkg::OP_ASR:   simple = 64'($signed(a) >>> ctl.sh);
         esc_pkg::OP_SHL:   simple = a << ctl.sh;
         esc_pkg::OP_LSR:   simple = a >> ctl.sh;
         esc_pkg::OP_ZSEL:  simple = (b == 64'd0) ? 64'd0 : a;
         esc_pkg::OP_DINP:  simple = a[31] ? a : (a << 1);
         esc_pkg::OP_DOUTP: simple = a[31] ? (b << 1) : b;
         esc_pkg::OP_HFIN: begin
            if (a[63])
               simple = 64'd0;
            else if (a > esc_pkg::K_HUM_MAX)
               simple = esc_pkg::K_HUM_MAX >> 12;
            else
               simple = a >> 12;
         end
         default:           simple = 64'd0;
      endcase
   end

   // multiply: one 16-bit slice of b per cycle
   assign chunk  = b_ff[{cnt_ff[1:0], 4'd0} +: 16];
   assign part   = {16'd0, a_ff} * {64'd0, chunk};
   assign acc_in = acc_ff + (part[63:0] << {cnt_ff[1:0], 4'd0});

   // divide: restoring, one quotient bit per cycle on magnitudes
   assign rem_sh = {rem_ff, quo_ff[63]};
   assign diff   = rem_sh - {1'b0, b_ff};
   assign rem_in = diff[64] ? rem_sh[63:0] : diff[63:0];
   assign quo_in = {quo_ff[62:0], ~diff[64]};
   assign quo_signed = neg_ff ? (64'd0 - quo_in) : quo_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            op_ff   <= ctl.op;
            mode_ff <= ctl.mode;
            cnt_ff  <= 6'd0;
            if (ctl.op == esc_pkg::OP_MUL) begin
               busy_ff <= 1'b1;
               a_ff    <= a;
               b_ff    <= b;
               acc_ff  <= 64'd0;
            end else if (ctl.op == esc_pkg::OP_DIV) begin
               busy_ff <= 1'b1;
               quo_ff  <= a[63] ? (64'd0 - a) : a;
               b_ff    <= b[63] ? (64'd0 - b) : b;
               rem_ff  <= 64'd0;
               neg_ff  <= a[63] ^ b[63];
            end else begin
               res_ff  <= fit(ctl.mode, simple);
               done_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (op_ff == esc_pkg::OP_MUL) begin
               acc_ff <= acc_in;
               if (cnt_ff[1:0] == 2'd3) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
                  res_ff  <= fit(mode_ff, acc_in);
               end
            end else begin
               rem_ff <= rem_in;
               quo_ff <= quo_in;
               if (cnt_ff == 6'd63) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
                  res_ff  <= fit(mode_ff, quo_signed);
               end
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

>>> src/esc_rf.sv
// Scratch register memory and operand selection with registered read ports.
`timescale 1ns / 1ps
module esc_rf (
   input  logic                 clock,
   input  esc_pkg::trim_type    trim,
   input  logic [31:0]          fine,
   input  logic [19:0]          raw_t,
   input  logic [19:0]          raw_p,
   input  logic [15:0]          raw_h,
   input  logic                 rd_en,
   input  logic [5:0]           src_a,
   input  logic [5:0]           src_b,
   input  logic                 we,
   input  logic [3:0]           waddr,
   input  logic [63:0]          wdata,
   output logic [63:0]          opa,
   output logic [63:0]          opb
);

   logic [63:0] mem [16];
   logic [63:0] opa_ff;
   logic [63:0] opb_ff;

   function automatic logic [63:0] s16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] special(input logic [5:0] src, input esc_pkg::trim_type t,
                                           input logic [31:0] f, input logic [19:0] rt,
                                           input logic [19:0] rp, input logic [15:0] rh);
      logic [63:0] v;
      case (src)
         esc_pkg::SRC_T1:       v = {48'd0, t.temp[15:0]};
         esc_pkg::SRC_T2:       v = s16(t.temp[31:16]);
         esc_pkg::SRC_T3:       v = s16(t.temp[47:32]);
         esc_pkg::SRC_P1:       v = {48'd0, t.plow[15:0]};
         esc_pkg::SRC_P2:       v = s16(t.plow[31:16]);
         esc_pkg::SRC_P3:       v = s16(t.plow[47:32]);
         esc_pkg::SRC_P4:       v = s16(t.plow[63:48]);
         esc_pkg::SRC_P5:       v = s16(t.phigh[15:0]);
         esc_pkg::SRC_P6:       v = s16(t.phigh[31:16]);
         esc_pkg::SRC_P7:       v = s16(t.phigh[47:32]);
         esc_pkg::SRC_P8:       v = s16(t.phigh[63:48]);
         esc_pkg::SRC_P9:       v = s16(t.p9);
         esc_pkg::SRC_H1:       v = {56'd0, t.hum[7:0]};
         esc_pkg::SRC_H2:       v = s16(t.hum[23:8]);
         esc_pkg::SRC_H3:       v = {56'd0, t.hum[31:24]};
         esc_pkg::SRC_H4:       v = {{52{t.hum[43]}}, t.hum[43:32]};
         esc_pkg::SRC_H5:       v = {{52{t.hum[55]}}, t.hum[55:44]};
         esc_pkg::SRC_H6:       v = {{56{t.hum[63]}}, t.hum[63:56]};
         esc_pkg::SRC_FINE:     v = {{32{f[31]}}, f};
         esc_pkg::SRC_RT:       v = {44'd0, rt};
         esc_pkg::SRC_RP:       v = {44'd0, rp};
         esc_pkg::SRC_RH:       v = {48'd0, rh};
         esc_pkg::SRC_K128000:  v = 64'd128000;
         esc_pkg::SRC_K3125:    v = 64'd3125;
         esc_pkg::SRC_K1048576: v = 64'd1048576;
         esc_pkg::SRC_K64000:   v = 64'd64000;
         esc_pkg::SRC_K76800:   v = 64'd76800;
         esc_pkg::SRC_K16384:   v = 64'd16384;
         esc_pkg::SRC_K2097152: v = 64'd2097152;
         esc_pkg::SRC_K128:     v = 64'd128;
         esc_pkg::SRC_K5:       v = 64'd5;
         esc_pkg::SRC_K2P47:    v = 64'h0000_8000_0000_0000;
         esc_pkg::SRC_K32768:   v = 64'd32768;
         esc_pkg::SRC_K8192:    v = 64'd8192;
         default:               v = 64'd0;
      endcase
      return v;
   endfunction

   always_ff @(posedge clock) begin
      if (we)
         mem[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         opa_ff <= (src_a[5:4] == 2'd0) ? mem[src_a[3:0]]
                                        : special(src_a, trim, fine, raw_t, raw_p, raw_h);
         opb_ff <= (src_b[5:4] == 2'd0) ? mem[src_b[3:0]]
                                        : special(src_b, trim, fine, raw_t, raw_p, raw_h);
      end
   end

   assign opa = opa_ff;
   assign opb = opb_ff;

endmodule

>>> src/environment_sensor_compensation_core.sv
// Top level: item handshake, trim registers, microcode sequencer and result beat.
// Each item runs its present segments in the order temperature, pressure (64-bit or
//   32-bit path) and humidity, each after a dispatch state, then loads the result beat.
// Each microcode step passes through the read, execute and wait states; a multiply or
//   the divide holds the wait state until the ALU finishes. An item from an absent
//   device runs no microcode and goes straight to the result beat.
// Throughput: one item at a time; a new item is accepted only in the idle state, after
//   the previous result has loaded into a free result register.
// Reset is synchronous, active high; it clears the trims, fine temperature and control.
`timescale 1ns / 1ps
module environment_sensor_compensation_core (
   input  logic         clock,
   input  logic         reset,
   // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,
   // device_answered[0]
   input  logic         req_tuser,
   // temperature_centi[31:0], pressure_value[63:32], humidity_q10[80:64]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,
   // temperature_present[0], pressure_present[1], humidity_present[2]
   output logic [2:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [63:0]  csr_wdata
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_READ     = 3'd2;
   localparam logic [2:0] ST_EXEC     = 3'd3;
   localparam logic [2:0] ST_WAIT     = 3'd4;
   localparam logic [2:0] ST_FIN      = 3'd5;

   esc_pkg::trim_type     trim_ff;
   logic                  fmt_ff;
   logic [31:0]           fine_ff;

   logic [2:0]            state_ff;
   logic [6:0]            pc_ff;
   logic [2:0]            pend_ff;   // {humidity, pressure, temperature} still to run
   logic [2:0]            pres_ff;
   logic [19:0]           rt_ff;
   logic [19:0]           rp_ff;
   logic [15:0]           rh_ff;
   logic [31:0]           wt_ff;
   logic [31:0]           wp_ff;
   logic [16:0]           wh_ff;

   logic                  rsp_valid_ff;
   logic [87:0]           rsp_data_ff;
   logic [2:0]            rsp_user_ff;

   esc_pkg::uop_type      uop;
   esc_pkg::alu_ctl_type  alu_ctl;
   logic                  alu_done;
   logic [63:0]           alu_res;
   logic [63:0]           opa;
   logic [63:0]           opb;
   logic                  req_acc;
   logic                  rf_we;
   logic [6:0]            seg_pc;
   logic [2:0]            seg_clr;
   logic                  pres_t;
   logic                  pres_p;
   logic                  pres_h;

   assign uop        = esc_pkg::esc_ucode(pc_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;

   assign pres_t = req_tuser & (req_tdata[19:0] != esc_pkg::SKIP_TP);
   assign pres_p = req_tuser & (req_tdata[39:20] != esc_pkg::SKIP_TP);
   assign pres_h = req_tuser & (req_tdata[55:40] != esc_pkg::SKIP_H);

   // pick the next pending segment in the order temperature, pressure, humidity
   always_comb begin
      seg_pc  = esc_pkg::PC_TEMP;
      seg_clr = 3'b000;
      if (pend_ff[0]) begin
         seg_pc  = esc_pkg::PC_TEMP;
         seg_clr = 3'b001;
      end else if (pend_ff[1]) begin
         seg_pc  = fmt_ff ? esc_pkg::PC_P32 : esc_pkg::PC_P64;
         seg_clr = 3'b010;
      end else if (pend_ff[2]) begin
         seg_pc  = esc_pkg::PC_HUM;
         seg_clr = 3'b100;
      end
   end

   assign alu_ctl.start = (state_ff == ST_EXEC);
   assign alu_ctl.op    = uop.op;
   assign alu_ctl.mode  = uop.mode;
   assign alu_ctl.sh    = uop.sh;

   assign rf_we = (state_ff == ST_WAIT) && alu_done && !uop.dst[4];

   esc_rf u_rf (
      .clock (clock),
      .trim  (trim_ff),
      .fine  (fine_ff),
      .raw_t (rt_ff),
      .raw_p (rp_ff),
      .raw_h (rh_ff),
      .rd_en (state_ff == ST_READ),
      .src_a (uop.src_a),
      .src_b (uop.src_b),
      .we    (rf_we),
      .waddr (uop.dst[3:0]),
      .wdata (alu_res),
      .opa   (opa),
      .opb   (opb)
   );

   esc_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .a      (opa),
      .b      (opb),
      .done   (alu_done),
      .result (alu_res)
   );

   // trim registers; unknown indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         trim_ff <= '0;
         fmt_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            esc_pkg::CSR_TEMP_TRIM:   trim_ff.temp  <= csr_wdata[47:0];
            esc_pkg::CSR_PRESS_LOW:   trim_ff.plow  <= csr_wdata;
            esc_pkg::CSR_PRESS_HIGH:  trim_ff.phigh <= csr_wdata;
            esc_pkg::CSR_PRESS_NINTH: trim_ff.p9    <= csr_wdata[15:0];
            esc_pkg::CSR_HUM_TRIM:    trim_ff.hum   <= csr_wdata;
            esc_pkg::CSR_PRESS_FMT:   fmt_ff        <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 3'b000;
         fine_ff      <= 32'd0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= esc_pkg::PC_TEMP;
      end else begin
         // drop the beat once taken, unless a new one loads in this cycle
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_FIN))
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  rt_ff    <= req_tdata[19:0];
                  rp_ff    <= req_tdata[39:20];
                  rh_ff    <= req_tdata[55:40];
                  pend_ff  <= {pres_h, pres_p, pres_t};
                  pres_ff  <= {pres_h, pres_p, pres_t};
                  wt_ff    <= 32'd0;
                  wp_ff    <= 32'd0;
                  wh_ff    <= 17'd0;
                  state_ff <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               if (pend_ff == 3'b000) begin
                  state_ff <= ST_FIN;
               end else begin
                  pc_ff    <= seg_pc;
                  pend_ff  <= pend_ff & ~seg_clr;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: state_ff <= ST_EXEC;
            ST_EXEC: state_ff <= ST_WAIT;
            ST_WAIT: begin
               if (alu_done) begin
                  case (uop.dst)
                     esc_pkg::DST_FINE:  fine_ff <= alu_res[31:0];
                     esc_pkg::DST_OUT_T: wt_ff   <= alu_res[31:0];
                     esc_pkg::DST_OUT_P: wp_ff   <= alu_res[31:0];
                     esc_pkg::DST_OUT_H: wh_ff   <= alu_res[16:0];
                     default: ;
                  endcase
                  if (uop.last) begin
                     state_ff <= ST_DISPATCH;
                  end else begin
                     pc_ff    <= pc_ff + 7'd1;
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_FIN: begin
               // hold until the result register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {7'd0, wh_ff, wp_ff, wt_ff};
                  rsp_user_ff  <= pres_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // the ALU only finishes while the sequencer waits on it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> (state_ff == ST_WAIT))
      else $error("ALU completion outside wait state");

   // an absent device goes straight to the result beat
   a_absent_direct: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !req_tuser) |=> ##1 (state_ff == ST_FIN))
      else $error("absent device item ran the microcode");

   // humidity never leaves its clamp range
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[80:64] <= 17'd102400))
      else $error("humidity out of range");

endmodule
